@@ rtl/core/znve_pkg.sv @@
// Package for the natural varint encoder: command type passed from the
// front end to the back end, phase type of the back end, and constants.
// No dependencies.
package znve_pkg;

  localparam int unsigned GROUP_BITS  = 7;
  localparam int unsigned PEND_BITS   = 6;
  localparam int unsigned CNT_BITS    = 3;
  localparam int unsigned ACC_BITS    = 14;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_BITS-1:0] MAX_PEND_CNT = 3'd6;
  localparam logic [3:0]          BYTE_BITS    = 4'd8;
  localparam logic [3:0]          GROUP_LEN    = 4'd7;
  localparam logic [3:0]          TWO_GROUPS   = 4'd14;
  localparam logic                MORE_FLAG    = 1'b1;

  // One request as classified by the front end: one or two code bytes.
  typedef struct packed {
    logic [7:0] code0;
    logic       last0;
    logic       has2;
    logic [7:0] code1;
    logic       last1;
  } cmd_t;

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_t;

endpackage

@@ rtl/core/znve_if.sv @@
// Valid/ready channel interfaces for the natural varint encoder:
// input byte channel and encoded byte channel. No dependencies.
interface znve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface znve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_of_code;

  modport source (output valid, output code_byte, output end_of_code, input ready);
  modport sink   (input valid, input code_byte, input end_of_code, output ready);
endinterface

@@ rtl/core/zarith_natural_varint_encoder.sv @@
// Top level of the natural (unsigned LEB128) varint encoder: front end,
// command queue and back end. Uses znve_pkg, znve_if and the three submodules.
//
//   channel   direction  handshake          payload
//   in_chan   sink       valid / ready      data_byte[7:0], final_byte
//   out_chan  source     valid / ready      code_byte[7:0], end_of_code
//
// Each input byte yields one or two code bytes; the output register emits one
// code byte a cycle while the receiver is ready. The first code byte of a
// request passes through the queue and then the output register. The two-entry
// queue keeps input accepted while the output is stalled, until it is full.
// Synchronous reset clears the held bits, queue and output valid.
module zarith_natural_varint_encoder (
  input  logic        clk,
  input  logic        rst_n,
  znve_in_if.sink     in_chan,
  znve_out_if.source  out_chan
);

  logic           q_full;
  logic           q_not_empty;
  logic           push;
  logic           pop;
  znve_pkg::cmd_t push_cmd;
  znve_pkg::cmd_t head;

  znve_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  znve_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  znve_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_chan    (out_chan)
  );

endmodule

@@ rtl/core/znve_front.sv @@
// Front end: accepts input bytes, merges them with the held bits and
// classifies each request into one or two code bytes. Uses znve_pkg, znve_if.
module znve_front (
  input  logic                clk,
  input  logic                rst_n,
  znve_in_if.sink             in_chan,
  input  logic                q_full,
  output logic                push,
  output znve_pkg::cmd_t      push_cmd
);

  logic [znve_pkg::PEND_BITS-1:0] pend_r, pend_nxt;
  logic [znve_pkg::CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [znve_pkg::CNT_BITS-1:0]  cnt_eff;
  logic [znve_pkg::ACC_BITS-1:0]  acc;
  logic [3:0]                     total;
  logic                           upper_nz;

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

  always_comb begin
    cnt_eff  = (cnt_r > znve_pkg::MAX_PEND_CNT) ? znve_pkg::MAX_PEND_CNT : cnt_r;
    acc      = (znve_pkg::ACC_BITS'(in_chan.data_byte) << cnt_eff)
             | znve_pkg::ACC_BITS'(pend_r);
    total    = 4'(cnt_eff) + znve_pkg::BYTE_BITS;
    upper_nz = (acc[13:7] != 7'd0);

    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;

    if (in_chan.final_byte) begin
      // Flush: a second group only when bits remain above the first one.
      push_cmd.code0 = {upper_nz, acc[6:0]};
      push_cmd.last0 = !upper_nz;
      push_cmd.has2  = upper_nz;
      push_cmd.code1 = {1'b0, acc[13:7]};
      push_cmd.last1 = 1'b1;
      if (push) begin
        pend_nxt = '0;
        cnt_nxt  = '0;
      end
    end else begin
      push_cmd.code0 = {znve_pkg::MORE_FLAG, acc[6:0]};
      push_cmd.last0 = 1'b0;
      push_cmd.has2  = (total == znve_pkg::TWO_GROUPS);
      push_cmd.code1 = {znve_pkg::MORE_FLAG, acc[13:7]};
      push_cmd.last1 = 1'b0;
      if (push) begin
        if (total == znve_pkg::TWO_GROUPS) begin
          pend_nxt = '0;
          cnt_nxt  = '0;
        end else begin
          pend_nxt = acc[12:7];
          cnt_nxt  = 3'(total - znve_pkg::GROUP_LEN);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/znve_queue.sv @@
// Two-entry command queue between the front and back ends of the
// natural varint encoder. Uses znve_pkg.
module znve_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  znve_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output znve_pkg::cmd_t head
);

  znve_pkg::cmd_t                   mem_r [znve_pkg::QUEUE_DEPTH];
  logic [znve_pkg::QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [znve_pkg::QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [znve_pkg::QCNT_BITS-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == znve_pkg::QCNT_BITS'(znve_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == znve_pkg::QPTR_BITS'(znve_pkg::QUEUE_DEPTH - 1))
                 ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == znve_pkg::QPTR_BITS'(znve_pkg::QUEUE_DEPTH - 1))
                 ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/znve_back.sv @@
// Back end: walks the code bytes of the head command and drives them
// through the output register. Uses znve_pkg, znve_if.
module znve_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  znve_pkg::cmd_t head,
  output logic           pop,
  znve_out_if.source     out_chan
);

  znve_pkg::phase_t phase_r, phase_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       code_r, code_nxt;
  logic             end_r, end_nxt;
  logic             load;

  // The output register loads from a non-empty queue when empty or drained.
  assign load = q_not_empty && (!valid_r || out_chan.ready);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      znve_pkg::PH_FIRST: begin
        if (load && head.has2) phase_nxt = znve_pkg::PH_SECOND;
      end
      znve_pkg::PH_SECOND: begin
        if (load) phase_nxt = znve_pkg::PH_FIRST;
      end
      default: phase_nxt = znve_pkg::PH_FIRST;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop       = 1'b0;
    valid_nxt = valid_r && !out_chan.ready;
    code_nxt  = code_r;
    end_nxt   = end_r;
    case (phase_r)
      znve_pkg::PH_FIRST: begin
        if (load) begin
          pop       = !head.has2;
          valid_nxt = 1'b1;
          code_nxt  = head.code0;
          end_nxt   = head.last0;
        end
      end
      znve_pkg::PH_SECOND: begin
        if (load) begin
          pop       = 1'b1;
          valid_nxt = 1'b1;
          code_nxt  = head.code1;
          end_nxt   = head.last1;
        end
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= znve_pkg::PH_FIRST;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    end_r  <= end_nxt;
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.code_byte   = code_r;
  assign out_chan.end_of_code = end_r;

endmodule

@@ rtl/core/znve_checker.sv @@
// Port-level checker for the natural varint encoder and its bind to the
// top level. Uses only the top level's ports.
module znve_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_final,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_code,
  input logic       out_end
);

  logic [2:0] fin_cnt_r, fin_cnt_nxt;
  logic       fin_in;
  logic       fin_out;

  assign fin_in  = in_valid && in_ready && in_final;
  assign fin_out = out_valid && out_ready && out_end;

  // Numbers whose final byte was taken but whose last code byte is not out.
  always_comb begin
    fin_cnt_nxt = fin_cnt_r;
    if (fin_in && !fin_out) begin
      fin_cnt_nxt = fin_cnt_r + 1'b1;
    end else if (fin_out && !fin_in) begin
      fin_cnt_nxt = fin_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_cnt_r <= '0;
    end else begin
      fin_cnt_r <= fin_cnt_nxt;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_end))
    else $error("code byte changed while stalled");

  a_flag_matches_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_code[7] != out_end))
    else $error("continuation bit disagrees with end of code");

  a_end_has_final: assert property (@(posedge clk) disable iff (!rst_n)
    fin_out |-> (fin_cnt_r != 3'd0))
    else $error("end of code without a final input byte");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind zarith_natural_varint_encoder znve_checker u_znve_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_final  (in_chan.final_byte),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_code  (out_chan.code_byte),
  .out_end   (out_chan.end_of_code)
);

@@ verif/znve_code_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the natural varint encoder: watches the input and code byte
// channels, predicts the code bytes of every accepted request and compares.
// Depends on znve_pkg and the channel interfaces in znve_if.
module znve_code_checker (
  input  logic        clk,
  input  logic        rst_n,
  znve_in_if          in_mon,
  znve_out_if         out_mon,
  output int unsigned mismatches,
  output int unsigned codes_outstanding,
  output int unsigned codes_checked,
  output int unsigned bytes_taken,
  output int unsigned numbers_closed
);

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_code;
  } code_t;

  code_t                          code_q[$];
  logic [znve_pkg::PEND_BITS-1:0] held_bits;
  logic [znve_pkg::CNT_BITS-1:0]  held_cnt;
  int unsigned                    err_n;
  int unsigned                    chk_n;
  int unsigned                    byte_n;
  int unsigned                    num_n;

  // Splits the held bits plus one new byte into 7-bit groups.
  function automatic void encode_request(input logic [7:0] data, input logic fin);
    logic [znve_pkg::ACC_BITS-1:0] acc;
    int unsigned                   total;
    code_t                         c;
    acc   = znve_pkg::ACC_BITS'(held_bits) | (znve_pkg::ACC_BITS'(data) << held_cnt);
    total = held_cnt + 8;
    if (!fin) begin
      while (total >= znve_pkg::GROUP_BITS) begin
        c.code_byte   = {znve_pkg::MORE_FLAG, acc[znve_pkg::GROUP_BITS-1:0]};
        c.end_of_code = 1'b0;
        code_q.push_back(c);
        acc   = acc >> znve_pkg::GROUP_BITS;
        total = total - znve_pkg::GROUP_BITS;
      end
      held_bits = acc[znve_pkg::PEND_BITS-1:0];
      held_cnt  = znve_pkg::CNT_BITS'(total);
    end else begin
      // The last number byte drains everything, but never emits a group of
      // pure zero padding beyond the first one.
      do begin
        c.code_byte[znve_pkg::GROUP_BITS-1:0] = acc[znve_pkg::GROUP_BITS-1:0];
        acc = acc >> znve_pkg::GROUP_BITS;
        c.code_byte[7]  = (acc != '0);
        c.end_of_code   = (acc == '0);
        code_q.push_back(c);
      end while (acc != '0);
      held_bits = '0;
      held_cnt  = '0;
    end
  endfunction

  always @(posedge clk) begin
    code_t got;
    code_t want;
    if (!rst_n) begin
      code_q.delete();
      held_bits = '0;
      held_cnt  = '0;
      err_n     = 0;
      chk_n     = 0;
      byte_n    = 0;
      num_n     = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        encode_request(in_mon.data_byte, in_mon.final_byte);
        byte_n++;
        if (in_mon.final_byte) num_n++;
      end
      if (out_mon.valid && out_mon.ready) begin
        got.code_byte   = out_mon.code_byte;
        got.end_of_code = out_mon.end_of_code;
        chk_n++;
        if (code_q.size() == 0) begin
          $display("%0t: code byte %02h end_of_code %0b with nothing expected",
                   $time, got.code_byte, got.end_of_code);
          err_n++;
        end else begin
          want = code_q.pop_front();
          if (got.code_byte !== want.code_byte) begin
            $display("%0t: code_byte expected %02h actual %02h",
                     $time, want.code_byte, got.code_byte);
            err_n++;
          end
          if (got.end_of_code !== want.end_of_code) begin
            $display("%0t: end_of_code expected %0b actual %0b",
                     $time, want.end_of_code, got.end_of_code);
            err_n++;
          end
        end
      end
    end
    mismatches        <= err_n;
    codes_outstanding <= code_q.size();
    codes_checked     <= chk_n;
    bytes_taken       <= byte_n;
    numbers_closed    <= num_n;
  end

endmodule

@@ verif/zarith_natural_varint_encoder_tb.sv @@
`timescale 1ns / 100ps
// Top of the natural varint encoder testbench: clock, reset, paced byte
// stimulus and receiver stalls. Depends on znve_if, the block and znve_code_checker.
module zarith_natural_varint_encoder_tb;

  localparam logic LAST_BYTE  = 1'b1;
  localparam logic MORE_BYTES = 1'b0;
  localparam int unsigned RAND_BYTES = 550;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned codes_outstanding;
  int unsigned codes_checked;
  int unsigned bytes_taken;
  int unsigned numbers_closed;
  int unsigned burst_left;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned rand_sent;

  always #10 clk = ~clk;

  znve_in_if  in_if ();
  znve_out_if out_if ();

  zarith_natural_varint_encoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  znve_code_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_if),
    .out_mon           (out_if),
    .mismatches        (mismatches),
    .codes_outstanding (codes_outstanding),
    .codes_checked     (codes_checked),
    .bytes_taken       (bytes_taken),
    .numbers_closed    (numbers_closed)
  );

  // Offers one request, waits for its acceptance, then idles between bursts.
  task automatic push_byte(input logic [7:0] data, input logic fin);
    int unsigned gap;
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= data;
    in_if.final_byte <= fin;
    do @(posedge clk); while (!(in_if.valid === 1'b1 && in_if.ready === 1'b1));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A number of random length; sometimes its top bytes are left as zeros.
  task automatic send_number();
    int unsigned len;
    int unsigned zero_top;
    int unsigned sel;
    logic [7:0]  b;
    sel = $urandom_range(0, 19);
    if (sel < 10)      len = $urandom_range(1, 2);
    else if (sel < 16) len = $urandom_range(3, 6);
    else if (sel < 19) len = $urandom_range(7, 32);
    else               len = $urandom_range(33, 40);
    zero_top = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    for (int unsigned i = 0; i < len; i++) begin
      b = (i + zero_top >= len) ? 8'h00 : pick_byte();
      push_byte(b, (i == len - 1) ? LAST_BYTE : MORE_BYTES);
      rand_sent++;
    end
  endtask

  // Receiver: changes its stall pattern now and then, and performs a long
  // hold-off whenever the stimulus asks for one.
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    rx_mode_t    mode;
    hold_left = 0;
    mode_left = 0;
    mode      = RX_OPEN;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done && hold_left == 0) begin
        hold_left  = HOLD_CYCLES;
        holds_done = holds_asked;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_RANDOM: out_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= ~out_if.ready;
        endcase
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.data_byte  <= 8'h00;
    in_if.final_byte <= 1'b0;
    burst_left = $urandom_range(1, 12);
    rand_sent  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero value and single-byte extremes.
    push_byte(8'h00, LAST_BYTE);
    push_byte(8'h7f, LAST_BYTE);
    push_byte(8'h80, LAST_BYTE);
    push_byte(8'hff, LAST_BYTE);
    // All ones: held bits grow to six, then a final 01 closes them in one group.
    repeat (6) push_byte(8'hff, MORE_BYTES);
    push_byte(8'h01, LAST_BYTE);
    // Unstripped zero high bytes give extra continuation groups.
    push_byte(8'h05, MORE_BYTES);
    push_byte(8'h00, MORE_BYTES);
    push_byte(8'h00, LAST_BYTE);
    push_byte(8'h00, MORE_BYTES);
    push_byte(8'h00, LAST_BYTE);
    push_byte(8'h80, MORE_BYTES);
    push_byte(8'h00, LAST_BYTE);
    push_byte(8'h01, MORE_BYTES);
    push_byte(8'hff, LAST_BYTE);

    while (rand_sent < RAND_BYTES) begin
      if (holds_asked == 0 && rand_sent >= 200) begin
        // Keep requests coming while the output is held off.
        holds_asked++;
        burst_left = 40;
      end
      send_number();
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (codes_outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Encoded %0d numbers from %0d input bytes; %0d code bytes checked.",
             numbers_closed, bytes_taken, codes_checked);
    $display("Sender bursts and gaps, varied receiver stalls and one long hold-off.");
    if (mismatches == 0 && codes_outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/znve_pkg.sv
rtl/core/znve_if.sv
rtl/core/znve_front.sv
rtl/core/znve_queue.sv
rtl/core/znve_back.sv
rtl/core/zarith_natural_varint_encoder.sv
rtl/core/znve_checker.sv
verif/znve_code_checker.sv
verif/zarith_natural_varint_encoder_tb.sv
